### sv/http_response_header_parser_defines.svh
// Assertion macros for the HTTP response header parser checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH
`define HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define HRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define HRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/hrp_pkg.sv
// Shared types, character codes and helper functions for the HTTP
// response header parser. No dependencies.
`default_nettype none

package hrp_pkg;

  // input and result words
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } hrp_in_t;

  typedef struct packed {
    logic [1:0]          parse_error;
    logic signed [15:0]  status_code;
    logic signed [31:0]  content_length;
    logic [15:0]         header_bytes;
    logic [4:0]          header_lines;
  } hrp_out_t;

  // error codes
  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_NO_TERM    = 2'd1;
  localparam logic [1:0] ERR_NO_VERSION = 2'd2;
  localparam logic [1:0] ERR_NO_STATUS  = 2'd3;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // header name compare
  localparam int KEY_LEN            = 14;
  localparam int NAME_COMPARE_LIMIT = 64;
  localparam logic NAME_TAIL_CHECK  = (NAME_COMPARE_LIMIT - 1) > KEY_LEN;
  localparam logic [7:0] NAME_CNT_MAX = 8'hFF;

  // saturation limits of the magnitudes
  localparam logic [31:0] ST_CAP  = 32'd32768;
  localparam logic [31:0] LEN_CAP = 32'h8000_0000;
  localparam logic [15:0] BYTES_MAX = 16'hFFFF;

  // terminator progress codes
  localparam logic [1:0] TP_NONE   = 2'd0;
  localparam logic [1:0] TP_CR     = 2'd1;
  localparam logic [1:0] TP_CRLF   = 2'd2;
  localparam logic [1:0] TP_CRLFCR = 2'd3;

  typedef enum logic [3:0] {
    PH_PRE_VERSION,
    PH_IN_VERSION,
    PH_PRE_STATUS,
    PH_IN_STATUS,
    PH_AFTER_STATUS,
    PH_LEAD,
    PH_NAME,
    PH_VALUE,
    PH_IGNORE_LINE,
    PH_SKIP_ALL,
    PH_NO_VERSION,
    PH_NO_STATUS
  } phase_e;

  typedef enum logic [1:0] {
    NS_BEFORE,
    NS_DIGITS,
    NS_STOPPED
  } num_stage_e;

  // parser state except the line count
  typedef struct packed {
    phase_e      phase;
    logic [1:0]  term;
    logic [15:0] bytes;
    logic [15:0] st_mag;
    logic        st_neg;
    num_stage_e  nstage;
    logic [7:0]  name_cnt;
    logic        name_ok;
    logic        len_found;
    logic [31:0] len_mag;
    logic        len_neg;
    logic        done;
  } hrp_state_t;

  localparam hrp_state_t STATE_RST = '{
    phase:     PH_PRE_VERSION,
    term:      TP_NONE,
    bytes:     16'd0,
    st_mag:    16'd0,
    st_neg:    1'b0,
    nstage:    NS_BEFORE,
    name_cnt:  8'd0,
    name_ok:   1'b1,
    len_found: 1'b0,
    len_mag:   32'd0,
    len_neg:   1'b0,
    done:      1'b0
  };

  typedef struct packed {
    num_stage_e  stage;
    logic [31:0] mag;
    logic        neg;
  } num_res_t;

  // lower-case key, one character per index
  function automatic logic [7:0] key_char(logic [3:0] p);
    logic [7:0] k;
    case (p)
      4'd0:    k = 8'h63; // c
      4'd1:    k = 8'h6F; // o
      4'd2:    k = 8'h6E; // n
      4'd3:    k = 8'h74; // t
      4'd4:    k = 8'h65; // e
      4'd5:    k = 8'h6E; // n
      4'd6:    k = 8'h74; // t
      4'd7:    k = 8'h2D; // -
      4'd8:    k = 8'h6C; // l
      4'd9:    k = 8'h65; // e
      4'd10:   k = 8'h6E; // n
      4'd11:   k = 8'h67; // g
      4'd12:   k = 8'h74; // t
      4'd13:   k = 8'h68; // h
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // one character into an atoi-style number
  function automatic num_res_t num_feed(num_stage_e stage, logic [31:0] mag,
                                        logic neg, logic [7:0] c,
                                        logic [31:0] cap);
    num_res_t    r;
    logic [35:0] v;
    logic        go;
    r  = '{stage: stage, mag: mag, neg: neg};
    go = 1'b0;
    v  = (36'(mag) << 3) + (36'(mag) << 1) + 36'(c - CH_0);
    case (stage)
      NS_BEFORE: begin
        if (!is_ws(c)) begin
          if ((c == CH_PLUS) || (c == CH_MINUS)) begin
            if (c == CH_MINUS) r.neg = 1'b1;
            r.stage = NS_DIGITS;
          end else begin
            go = 1'b1;
          end
        end
      end
      NS_DIGITS: go = 1'b1;
      default: ;
    endcase
    if (go) begin
      if ((c >= CH_0) && (c <= CH_9)) begin
        r.stage = NS_DIGITS;
        r.mag   = (v > 36'(cap)) ? cap : v[31:0];
      end else begin
        r.stage = NS_STOPPED;
      end
    end
    return r;
  endfunction

  // one character of a header name
  function automatic hrp_state_t name_char(hrp_state_t x, logic [7:0] c);
    hrp_state_t r;
    logic [7:0] lc;
    r  = x;
    lc = ((c >= CH_UC_A) && (c <= CH_UC_Z)) ? (c + CASE_GAP) : c;
    if (32'(x.name_cnt) < KEY_LEN) begin
      if (lc != key_char(x.name_cnt[3:0])) r.name_ok = 1'b0;
    end else if ((c != CH_SP) && NAME_TAIL_CHECK) begin
      r.name_ok = 1'b0;
    end
    if (x.name_cnt != NAME_CNT_MAX) r.name_cnt = x.name_cnt + 8'd1;
    return r;
  endfunction

  function automatic logic [15:0] status_signed(logic [15:0] mag, logic neg);
    if (neg) return 16'd0 - mag;
    return (mag > 16'h7FFF) ? 16'h7FFF : mag;
  endfunction

  function automatic logic [31:0] length_signed(logic [31:0] mag, logic neg);
    if (neg) return 32'd0 - mag;
    return (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
  endfunction

endpackage

`default_nettype wire

### sv/hrp_in_reg.sv
// Input register of the header parser: holds one accepted byte word.
// Depends on hrp_pkg.
`default_nettype none

module hrp_in_reg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire hrp_pkg::hrp_in_t in_data_i,
  input  wire logic            adv_i,
  output logic                 q_valid_o,
  output hrp_pkg::hrp_in_t     q_data_o
);
  import hrp_pkg::*;

  logic    valid_q, valid_d;
  hrp_in_t data_q;
  logic    take;

  // a held word blocks the port until the core consumes it
  assign in_stall_o = valid_q && !adv_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take)       valid_d = 1'b1;
    else if (adv_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) data_q <= in_data_i;
  end

  assign q_valid_o = valid_q;
  assign q_data_o  = data_q;

endmodule

`default_nettype wire

### sv/hrp_core.sv
// Parser state and per-byte next-state logic; builds the result word.
// Depends on hrp_pkg.
`default_nettype none

module hrp_core #(
  parameter int MAX_HEADER_LINES = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire hrp_pkg::hrp_in_t byte_i,
  output logic                  res_valid_o,
  output hrp_pkg::hrp_out_t     res_o
);
  import hrp_pkg::*;

  localparam int LcW = $clog2(MAX_HEADER_LINES + 1);

  typedef struct packed {
    hrp_state_t     s;
    logic [LcW-1:0] lines;
  } ctx_t;

  hrp_state_t     st_q;
  logic [LcW-1:0] lines_q;
  ctx_t           cur, nxt;
  logic           emit, pend;
  logic [1:0]     err;
  logic [7:0]     c;
  logic [31:0]    lines_ext;

  function automatic ctx_t start_header_line(ctx_t x);
    ctx_t r;
    r = x;
    if (x.lines >= LcW'(MAX_HEADER_LINES)) begin
      r.s.phase = PH_SKIP_ALL;
    end else begin
      r.s.phase    = PH_LEAD;
      r.s.name_cnt = 8'd0;
      r.s.name_ok  = 1'b1;
    end
    return r;
  endfunction

  function automatic ctx_t line_break(ctx_t x);
    ctx_t r;
    r = x;
    case (x.s.phase) inside
      PH_PRE_VERSION:                r.s.phase = PH_NO_VERSION;
      PH_IN_VERSION, PH_PRE_STATUS:  r.s.phase = PH_NO_STATUS;
      PH_IN_STATUS, PH_AFTER_STATUS, PH_LEAD, PH_NAME, PH_VALUE,
      PH_IGNORE_LINE:                r = start_header_line(x);
      default: ;
    endcase
    return r;
  endfunction

  // colon closes the name: first matching name opens the value
  function automatic ctx_t colon_seen(ctx_t x);
    ctx_t r;
    r = x;
    r.lines = LcW'(x.lines + 1'b1);
    if (!x.s.len_found && x.s.name_ok && (32'(x.s.name_cnt) >= KEY_LEN)) begin
      r.s.len_found = 1'b1;
      r.s.len_mag   = 32'd0;
      r.s.len_neg   = 1'b0;
      r.s.nstage    = NS_BEFORE;
      r.s.phase     = PH_VALUE;
    end else begin
      r.s.phase = PH_IGNORE_LINE;
    end
    return r;
  endfunction

  // one character through the phase machine
  function automatic ctx_t feed(ctx_t x, logic [7:0] ch);
    ctx_t     r;
    num_res_t n;
    r = x;
    n = '{stage: x.s.nstage, mag: x.s.len_mag, neg: x.s.len_neg};
    case (x.s.phase) inside
      PH_PRE_VERSION: if (ch != CH_SP) r.s.phase = PH_IN_VERSION;
      PH_IN_VERSION:  if (ch == CH_SP) r.s.phase = PH_PRE_STATUS;
      PH_PRE_STATUS, PH_IN_STATUS: begin
        if (ch == CH_SP) begin
          if (x.s.phase == PH_IN_STATUS) r.s.phase = PH_AFTER_STATUS;
        end else begin
          r.s.phase  = PH_IN_STATUS;
          n          = num_feed(x.s.nstage, 32'(x.s.st_mag), x.s.st_neg, ch, ST_CAP);
          r.s.nstage = n.stage;
          r.s.st_mag = n.mag[15:0];
          r.s.st_neg = n.neg;
        end
      end
      PH_LEAD: begin
        if (ch == CH_COLON) begin
          r = colon_seen(x);
        end else if (ch != CH_SP) begin
          r.s       = name_char(x.s, ch);
          r.s.phase = PH_NAME;
        end
      end
      PH_NAME: begin
        if (ch == CH_COLON) r = colon_seen(x);
        else                r.s = name_char(x.s, ch);
      end
      PH_VALUE: begin
        n           = num_feed(x.s.nstage, x.s.len_mag, x.s.len_neg, ch, LEN_CAP);
        r.s.nstage  = n.stage;
        r.s.len_mag = n.mag;
        r.s.len_neg = n.neg;
      end
      default: ;
    endcase
    return r;
  endfunction

  assign c = byte_i.data_byte;

  // next state for the word in the input register
  always_comb begin
    cur  = '{s: st_q, lines: lines_q};
    nxt  = cur;
    emit = 1'b0;
    err  = ERR_NO_TERM;
    pend = (cur.s.term == TP_CR) || (cur.s.term == TP_CRLFCR);
    if (!cur.s.done) begin
      if (c == CH_NUL) begin
        emit       = 1'b1;
        nxt.s.done = 1'b1;
      end else begin
        if (cur.s.bytes != BYTES_MAX) nxt.s.bytes = cur.s.bytes + 16'd1;
        if ((c == CH_LF) && (cur.s.term == TP_CRLFCR)) begin
          emit       = 1'b1;
          nxt.s.done = 1'b1;
          case (cur.s.phase) inside
            PH_PRE_VERSION, PH_NO_VERSION:               err = ERR_NO_VERSION;
            PH_IN_VERSION, PH_PRE_STATUS, PH_NO_STATUS:  err = ERR_NO_STATUS;
            default:                                     err = ERR_OK;
          endcase
        end else begin
          // a CR held back from the last word is either a line break or text
          if (pend) begin
            if (c == CH_LF) nxt = line_break(nxt);
            else            nxt = feed(nxt, CH_CR);
          end
          if ((c != CH_CR) && !(pend && (c == CH_LF))) nxt = feed(nxt, c);
          if (c == CH_CR)
            nxt.s.term = (cur.s.term == TP_CRLF) ? TP_CRLFCR : TP_CR;
          else if ((c == CH_LF) && (cur.s.term == TP_CR))
            nxt.s.term = TP_CRLF;
          else
            nxt.s.term = TP_NONE;
          if (byte_i.end_of_buffer) emit = 1'b1;
        end
      end
    end
  end

  // result word
  assign lines_ext = 32'(nxt.lines);

  always_comb begin
    res_o.parse_error    = err;
    res_o.status_code    = 16'hFFFF;
    res_o.content_length = 32'hFFFF_FFFF;
    res_o.header_bytes   = 16'd0;
    res_o.header_lines   = 5'd0;
    if (err != ERR_NO_TERM) res_o.header_bytes = nxt.s.bytes;
    if (err == ERR_OK) begin
      res_o.status_code = status_signed(nxt.s.st_mag, nxt.s.st_neg);
      if (nxt.s.len_found)
        res_o.content_length = length_signed(nxt.s.len_mag, nxt.s.len_neg);
      res_o.header_lines = lines_ext[4:0];
    end
  end

  assign res_valid_o = step_i && emit;

  // state register; last byte of a buffer restarts the parser
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= STATE_RST;
      lines_q <= '0;
    end else if (step_i) begin
      if (byte_i.end_of_buffer) begin
        st_q    <= STATE_RST;
        lines_q <= '0;
      end else begin
        st_q    <= nxt.s;
        lines_q <= nxt.lines;
      end
    end
  end

endmodule

`default_nettype wire

### sv/hrp_out_reg.sv
// Result register of the header parser; generates the advance strobe.
// Depends on hrp_pkg.
`default_nettype none

module hrp_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              out_stall_i,
  input  wire logic              res_valid_i,
  input  wire hrp_pkg::hrp_out_t res_i,
  output logic                   adv_o,
  output logic                   out_valid_o,
  output hrp_pkg::hrp_out_t      out_data_o
);
  import hrp_pkg::*;

  logic     valid_q, valid_d;
  hrp_out_t data_q;

  // free, or being taken this cycle
  assign adv_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (adv_o) valid_d = res_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && res_valid_i) data_q <= res_i;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

### sv/http_response_header_parser.sv
// HTTP response header parser, one byte word per cycle sustained unless the output
// side stalls. The byte ending a result is held in the input register, and the parser
// logic writes the result into the result register, which drives out_valid_o.
// The input stalls only while a result waits in the output register and the
// output side stalls. Asynchronous active-low reset returns the parser to the
// start of a status line; there is no clearing pass.
`default_nettype none

module http_response_header_parser #(
  parameter int MAX_HEADER_LINES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire hrp_pkg::hrp_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output hrp_pkg::hrp_out_t      out_data_o
);
  import hrp_pkg::*;

  logic     adv, q_valid, step, res_valid;
  hrp_in_t  q_data;
  hrp_out_t res;

  assign step = q_valid && adv;

  hrp_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .adv_i      (adv),
    .q_valid_o  (q_valid),
    .q_data_o   (q_data)
  );

  hrp_core #(
    .MAX_HEADER_LINES (MAX_HEADER_LINES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (q_data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hrp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .out_stall_i (out_stall_i),
    .res_valid_i (res_valid),
    .res_i       (res),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### sv/hrp_checker.sv
// Port-level checks for the HTTP response header parser, bound to the top.
// Depends on hrp_pkg and http_response_header_parser_defines.svh.
`default_nettype none
`include "http_response_header_parser_defines.svh"

module hrp_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire hrp_pkg::hrp_out_t out_data_o
);
  import hrp_pkg::*;

  // a stalled result stays put
  `HRP_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

  // input only stalls behind a blocked result
  `HRP_ASSERT_IMP(a_in_stall, !out_valid_o || !out_stall_i, !in_stall_o, "input stalled without cause")

  // missing terminator carries no numbers
  `HRP_ASSERT_IMP(a_no_term, out_valid_o && (out_data_o.parse_error == ERR_NO_TERM), (out_data_o.header_bytes == 16'd0) && (out_data_o.status_code == 16'hFFFF), "bad no-terminator result")

  // any error clears length and line count
  `HRP_ASSERT_IMP(a_err_fields, out_valid_o && (out_data_o.parse_error != ERR_OK), (out_data_o.content_length == 32'hFFFF_FFFF) && (out_data_o.header_lines == 5'd0), "bad error result")

  // a good header ends in four terminator bytes at least
  `HRP_ASSERT_IMP(a_ok_bytes, out_valid_o && (out_data_o.parse_error == ERR_OK), out_data_o.header_bytes >= 16'd4, "header too short")

endmodule

bind http_response_header_parser hrp_checker u_hrp_checker (.*);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for http_response_header_parser: directed and random
// response buffers are fed one byte word at a time against an in-bench parser model.
// Depends on hrp_pkg for the word types, error codes, phases and character codes.
`default_nettype none

module testbench;
  import hrp_pkg::*;

  localparam int              LINE_LIMIT   = 16;
  localparam int              KEY_CHARS    = 14;
  localparam logic [8*14-1:0] LENGTH_KEY   = "content-length";
  localparam longint unsigned STATUS_CAP   = 64'd32768;
  localparam longint unsigned LENGTH_CAP   = 64'h8000_0000;
  localparam int              CYCLE_LIMIT  = 1_000_000;
  localparam int              RANDOM_BYTES = 200;
  localparam int              RANDOM_MSGS  = 4;
  localparam string           EOL          = "\015\n";

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  hrp_in_t  in_data_i   = '0;
  logic     out_stall_i = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  hrp_out_t out_data_o;

  http_response_header_parser u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // parser model state
  phase_e          hp_phase;
  num_stage_e      hp_nstage;
  logic [1:0]      hp_term;
  int unsigned     hp_bytes;
  int unsigned     hp_name_cnt;
  int unsigned     hp_lines;
  longint unsigned hp_st_mag;
  longint unsigned hp_len_mag;
  bit              hp_st_neg;
  bit              hp_name_ok;
  bit              hp_len_found;
  bit              hp_len_neg;
  bit              hp_done;

  hrp_out_t    expected_headers[$];
  logic [7:0]  frame_q[$];
  int          errors     = 0;
  int          live_bytes = 0;
  int          cycles     = 0;
  bit          quiet      = 1'b0;

  // ---------------------------------------------------------------- model

  task automatic clear_parse_state();
    hp_phase     = PH_PRE_VERSION;
    hp_nstage    = NS_BEFORE;
    hp_term      = TP_NONE;
    hp_bytes     = 0;
    hp_name_cnt  = 0;
    hp_lines     = 0;
    hp_st_mag    = 0;
    hp_len_mag   = 0;
    hp_st_neg    = 1'b0;
    hp_name_ok   = 1'b1;
    hp_len_found = 1'b0;
    hp_len_neg   = 1'b0;
    hp_done      = 1'b0;
  endtask

  function automatic bit blank_char(logic [7:0] c);
    return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // atoi: skip blanks, one optional sign, then digits with a saturating magnitude
  task automatic atoi_step(input logic [7:0] c, input longint unsigned cap,
                           inout longint unsigned mag, inout bit neg);
    bit take;
    take = 1'b0;
    if (hp_nstage == NS_BEFORE) begin
      if (!blank_char(c)) begin
        hp_nstage = NS_DIGITS;
        if (c == CH_MINUS) neg = 1'b1;
        else if (c != CH_PLUS) take = 1'b1;
      end
    end else if (hp_nstage == NS_DIGITS) begin
      take = 1'b1;
    end
    if (take) begin
      if ((c >= CH_0) && (c <= CH_9)) begin
        mag = mag * 10 + (c - CH_0);
        if (mag > cap) mag = cap;
      end else begin
        hp_nstage = NS_STOPPED;
      end
    end
  endtask

  task automatic open_header_line();
    if (hp_lines >= LINE_LIMIT) begin
      hp_phase = PH_SKIP_ALL;
    end else begin
      hp_phase    = PH_LEAD;
      hp_name_cnt = 0;
      hp_name_ok  = 1'b1;
    end
  endtask

  task automatic end_of_line();
    case (hp_phase)
      PH_PRE_VERSION: hp_phase = PH_NO_VERSION;
      PH_IN_VERSION, PH_PRE_STATUS: hp_phase = PH_NO_STATUS;
      PH_IN_STATUS, PH_AFTER_STATUS, PH_LEAD, PH_NAME, PH_VALUE, PH_IGNORE_LINE:
        open_header_line();
      default: ;
    endcase
  endtask

  // name compare: key in any case, then only spaces may follow
  task automatic compare_name_char(input logic [7:0] c);
    logic [7:0] lc;
    lc = ((c >= CH_UC_A) && (c <= CH_UC_Z)) ? c + CASE_GAP : c;
    if (hp_name_cnt < KEY_CHARS) begin
      if (lc != LENGTH_KEY[8*(KEY_CHARS-1-hp_name_cnt) +: 8]) hp_name_ok = 1'b0;
    end else if (c != CH_SP) begin
      hp_name_ok = 1'b0;
    end
    if (hp_name_cnt < 255) hp_name_cnt++;
  endtask

  task automatic colon_found();
    hp_lines++;
    if (!hp_len_found && hp_name_ok && (hp_name_cnt >= KEY_CHARS)) begin
      hp_len_found = 1'b1;
      hp_len_mag   = 0;
      hp_len_neg   = 1'b0;
      hp_nstage    = NS_BEFORE;
      hp_phase     = PH_VALUE;
    end else begin
      hp_phase = PH_IGNORE_LINE;
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    case (hp_phase)
      PH_PRE_VERSION: if (c != CH_SP) hp_phase = PH_IN_VERSION;
      PH_IN_VERSION:  if (c == CH_SP) hp_phase = PH_PRE_STATUS;
      PH_PRE_STATUS: begin
        if (c != CH_SP) begin
          hp_phase = PH_IN_STATUS;
          atoi_step(c, STATUS_CAP, hp_st_mag, hp_st_neg);
        end
      end
      PH_IN_STATUS: begin
        if (c == CH_SP) hp_phase = PH_AFTER_STATUS;
        else atoi_step(c, STATUS_CAP, hp_st_mag, hp_st_neg);
      end
      PH_LEAD: begin
        if (c == CH_COLON) begin
          colon_found();
        end else if (c != CH_SP) begin
          hp_phase = PH_NAME;
          compare_name_char(c);
        end
      end
      PH_NAME: begin
        if (c == CH_COLON) colon_found();
        else compare_name_char(c);
      end
      PH_VALUE: atoi_step(c, LENGTH_CAP, hp_len_mag, hp_len_neg);
      default: ;
    endcase
  endtask

  task automatic push_header_result(input logic [1:0] err);
    hrp_out_t r;
    r.parse_error    = err;
    r.status_code    = '1;
    r.content_length = '1;
    r.header_bytes   = '0;
    r.header_lines   = '0;
    if (err != ERR_NO_TERM) r.header_bytes = hp_bytes[15:0];
    if (err == ERR_OK) begin
      r.status_code = hp_st_neg ? 16'(0 - hp_st_mag) :
                      (hp_st_mag > 64'h7FFF) ? 16'h7FFF : 16'(hp_st_mag);
      if (hp_len_found)
        r.content_length = hp_len_neg ? 32'(0 - hp_len_mag) :
                           (hp_len_mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(hp_len_mag);
      r.header_lines = 5'(hp_lines);
    end
    expected_headers.push_back(r);
  endtask

  // one accepted byte word into the model
  task automatic predict_header_byte(input logic [7:0] c, input logic eob);
    logic [1:0] prev;
    logic [1:0] err;
    bit         pend;
    if (!hp_done) begin
      if (c == CH_NUL) begin
        push_header_result(ERR_NO_TERM);
        hp_done = 1'b1;
      end else begin
        live_bytes++;
        prev = hp_term;
        if (hp_bytes < 65535) hp_bytes++;
        if ((c == CH_LF) && (prev == TP_CRLFCR)) begin
          err = ERR_OK;
          if ((hp_phase == PH_PRE_VERSION) || (hp_phase == PH_NO_VERSION))
            err = ERR_NO_VERSION;
          else if ((hp_phase == PH_IN_VERSION) || (hp_phase == PH_PRE_STATUS) ||
                   (hp_phase == PH_NO_STATUS))
            err = ERR_NO_STATUS;
          push_header_result(err);
          hp_done = 1'b1;
        end else begin
          // a held CR is either half a line break or an ordinary character
          pend = (prev == TP_CR) || (prev == TP_CRLFCR);
          if (pend) begin
            if (c == CH_LF) end_of_line();
            else parse_char(CH_CR);
          end
          if ((c != CH_CR) && !(pend && (c == CH_LF))) parse_char(c);
          if (c == CH_CR) hp_term = (prev == TP_CRLF) ? TP_CRLFCR : TP_CR;
          else if ((c == CH_LF) && (prev == TP_CR)) hp_term = TP_CRLF;
          else hp_term = TP_NONE;
          if (eob) push_header_result(ERR_NO_TERM);
        end
      end
    end
    if (eob) clear_parse_state();
  endtask

  // ------------------------------------------------------------- drivers

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!quiet && ($urandom_range(0, 5) == 0)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: b, end_of_buffer: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_header_byte(b, last);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endtask

  // whole buffer, end marker on its last byte
  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  // receiver stalls in bursts, with free stretches between
  int stall_left = 0;
  int free_left  = 0;
  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_stall_i <= 1'b1;
    end else begin
      free_left = $urandom_range(1, 30);
      out_stall_i <= 1'b0;
    end
  end

  // ------------------------------------------------------------- checker

  task automatic report(input string field, input longint want, input longint got);
    $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk_i) begin : check_results
    hrp_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_headers.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, out_data_o);
        errors++;
      end else begin
        want = expected_headers.pop_front();
        if (out_data_o.parse_error !== want.parse_error)
          report("parse_error", want.parse_error, out_data_o.parse_error);
        if (out_data_o.status_code !== want.status_code)
          report("status_code", want.status_code, out_data_o.status_code);
        if (out_data_o.content_length !== want.content_length)
          report("content_length", want.content_length, out_data_o.content_length);
        if (out_data_o.header_bytes !== want.header_bytes)
          report("header_bytes", want.header_bytes, out_data_o.header_bytes);
        if (out_data_o.header_lines !== want.header_lines)
          report("header_lines", want.header_lines, out_data_o.header_lines);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ------------------------------------------------------ random buffers

  task automatic put_letters(input int n);
    repeat (n) frame_q.push_back(8'($urandom_range("A", "z")));
  endtask

  // blanks, sign, digits (now and then enough to saturate), junk, lone CR
  task automatic put_number();
    int n;
    repeat ($urandom_range(0, 2)) frame_q.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
    case ($urandom_range(0, 7))
      0: frame_q.push_back(CH_MINUS);
      1: frame_q.push_back(CH_PLUS);
      default: ;
    endcase
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5);
    repeat (n) frame_q.push_back(8'($urandom_range(CH_0, CH_9)));
    if ($urandom_range(0, 4) == 0) put_letters(1);
    if ($urandom_range(0, 9) == 0) put_text("\0157");
  endtask

  task automatic put_random_name();
    logic [7:0] ch;
    if ($urandom_range(0, 7) <= 3) begin
      if ($urandom_range(0, 3) == 0) frame_q.push_back(CH_SP);
      for (int i = 0; i < KEY_CHARS; i++) begin
        ch = LENGTH_KEY[8*(KEY_CHARS-1-i) +: 8];
        if ((ch >= "a") && (ch <= "z") && $urandom_range(0, 1)) ch = ch - CASE_GAP;
        frame_q.push_back(ch);
      end
      case ($urandom_range(0, 5))
        0: void'(frame_q.pop_back());
        1: frame_q.push_back("s");
        2: frame_q[frame_q.size() - 1] = "x";
        3: repeat ($urandom_range(1, 3)) frame_q.push_back(CH_SP);
        default: ;
      endcase
    end else begin
      put_letters($urandom_range(1, 8));
    end
  endtask

  task automatic put_response();
    int r;
    int nl;
    // status line, sometimes missing its tokens
    r = $urandom_range(0, 19);
    if (r != 0) begin
      if (r == 2) frame_q.push_back(CH_SP);
      case ($urandom_range(0, 3))
        0:       put_text("HTTP/1.0");
        1, 2:    put_text("HTTP/1.1");
        default: put_letters($urandom_range(1, 6));
      endcase
      if (r == 1) begin
        if ($urandom_range(0, 1)) frame_q.push_back(CH_SP);
      end else begin
        repeat ($urandom_range(1, 2)) frame_q.push_back(CH_SP);
        put_number();
        if ($urandom_range(0, 1)) begin
          frame_q.push_back(CH_SP);
          put_letters($urandom_range(1, 6));
        end
      end
    end
    put_text(EOL);
    // header lines, now and then past the line limit
    nl = ($urandom_range(0, 11) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 3);
    repeat (nl) begin
      if ($urandom_range(0, 7) == 0) begin
        put_letters($urandom_range(1, 6));
      end else begin
        put_random_name();
        frame_q.push_back(CH_COLON);
        put_number();
      end
      put_text(EOL);
    end
    put_text(EOL);
  endtask

  // mostly well-formed responses; some noise, cut-off buffers and zero bytes
  task automatic send_random_buffer();
    int kind;
    int cut;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 24)) frame_q.push_back(8'($urandom));
    end else begin
      put_response();
      if (kind == 1) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end else begin
        if (kind == 2) frame_q.insert($urandom_range(0, frame_q.size()), CH_NUL);
        repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom));
      end
    end
    send_frame();
  endtask

  // --------------------------------------------------------------- tests

  task automatic test_ordinary_response();
    put_text({"HTTP/1.1 200 OK", EOL, "Content-Length: 42", EOL, "Host: x", EOL, EOL, "body"});
    send_frame();
    // terminator on the last byte of the buffer
    put_text({"HTTP/1.0 404 Not Found", EOL, EOL});
    send_frame();
  endtask

  task automatic test_missing_tokens();
    put_text({EOL, EOL});
    send_frame();
    put_text({"   ", EOL, "A: 1", EOL, EOL});
    send_frame();
    put_text({"HTTP/1.1", EOL, "A: 1", EOL, EOL});
    send_frame();
    put_text({"HTTP/1.1   ", EOL, EOL});
    send_frame();
  endtask

  task automatic test_buffer_end();
    // no terminator before the end marker
    put_text("HTTP/1.1 200");
    send_frame();
    // zero byte ends the buffer early, the rest is ignored
    put_text({"HTTP/1.1 200 OK", EOL});
    frame_q.push_back(CH_NUL);
    put_text("xyz");
    send_frame();
    frame_q.push_back(CH_NUL);
    send_frame();
    // bytes after the terminator, a zero among them
    put_text({"HTTP/1.1 204 OK", EOL, EOL});
    frame_q.push_back(CH_NUL);
    frame_q.push_back(8'hFF);
    send_frame();
    // lone and doubled CRs count as ordinary characters
    put_text({"HTTP/1.1 2\0150", EOL, "Content-Length:\0159", EOL, "X: a\015", EOL, "\015", EOL});
    put_text(EOL);
    send_frame();
  endtask

  task automatic test_number_limits();
    string st_cases [7] = '{"99999", "-99999", "+7", "-0042", "12ab", "\t-5", "OK"};
    string cl_cases [7] = '{" 99999999999", "-99999999999", "\t+12x3", "abc",
                            "-2147483648", "2147483648", "  -5"};
    for (int i = 0; i < 7; i++) begin
      put_text({"HTTP/1.1 ", st_cases[i], EOL, "Content-Length:", cl_cases[i], EOL, EOL});
      send_frame();
    end
  endtask

  task automatic test_header_names();
    string names [7] = '{"CoNtEnT-LeNgTh", " content-length  ", "content-lengthx",
                         "content-lengt", "", "content length", " content-length"};
    for (int i = 0; i < 7; i++) begin
      put_text({"HTTP/1.1 200 OK", EOL, names[i]});
      // very long trailing run saturates the name length count
      if (i == 6) repeat (290) frame_q.push_back(CH_SP);
      put_text({":12", EOL, "Content-Length: 99", EOL, EOL});
      send_frame();
    end
  endtask

  task automatic test_line_limit();
    // content-length as the seventeenth colon line lies past the limit
    put_text({"HTTP/1.1 200 OK", EOL});
    for (int i = 0; i < 18; i++) begin
      if (i == 3) put_text({"nocolon", EOL});
      if (i == 16) put_text({"Content-Length: 5", EOL});
      else         put_text({"X-Line: 1", EOL});
    end
    put_text(EOL);
    send_frame();
    // as the sixteenth it still counts
    put_text({"HTTP/1.1 200 OK", EOL});
    repeat (15) put_text({"X: 1", EOL});
    put_text({"content-length: 8", EOL, EOL});
    send_frame();
  endtask

  task automatic test_random_traffic();
    int base;
    int msgs;
    base = live_bytes;
    msgs = 0;
    while (((live_bytes - base) < RANDOM_BYTES) || (msgs < RANDOM_MSGS)) begin
      send_random_buffer();
      msgs++;
    end
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    repeat (4) send_random_buffer();
  endtask

  initial begin
    clear_parse_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_ordinary_response();
    test_missing_tokens();
    test_buffer_end();
    test_number_limits();
    test_header_names();
    test_line_limit();
    test_random_traffic();
    test_quiet_tail();
    in_valid_i <= 1'b0;
    while (expected_headers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
